@@ hw/rtl/bdq_pkg.sv @@
// Shared types and codes for the bounded deque with linear search.
`default_nettype none

package bdq_pkg;

	typedef enum logic [2:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_FIND       = 3'd4,
		ACT_CLEAR      = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ERR_OK         = 2'd0,
		ERR_POP_EMPTY  = 2'd1,
		ERR_PUSH_FULL  = 2'd2
	} err_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_SCAN = 1'b1
	} state_t;

	// Shift commands broadcast to every cell of the chain.
	typedef struct packed {
		logic shift_l;
		logic shift_r;
	} shift_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/bdq_cell.sv @@
// One storage cell of the deque chain, loading or taking data from a neighbor.
`default_nettype none

module bdq_cell
	import bdq_pkg::*;
#(
	parameter int unsigned WIDTH = 32
) (
	input  wire logic             clk,
	input  wire shift_ctrl_t      ctrl,
	input  wire logic             load,
	input  wire logic [WIDTH-1:0] load_data,
	input  wire logic [WIDTH-1:0] left_data,
	input  wire logic [WIDTH-1:0] right_data,
	output logic      [WIDTH-1:0] data
);

	logic [WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end else if (ctrl.shift_l) begin
			data_q <= right_data;
		end else if (ctrl.shift_r) begin
			data_q <= left_data;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

@@ hw/rtl/bounded_deque_with_search.sv @@
// Top level of the bounded deque: a chain of cells with the front entry in cell zero.
// Push front, push back, pop front, clear, unknown codes, and pop back or find on an
// empty deque give their result in the cycle after the item is accepted. Pop back and
// find on a non-empty deque first rotate the whole chain once past cell zero.
// A new item is accepted once the previous result is taken, in the cycle it is taken.
// Reset empties the deque and drops any pending result; stored values are not cleared.
`default_nettype none

module bounded_deque_with_search
	import bdq_pkg::*;
#(
	parameter int unsigned CAPACITY   = 16,
	parameter int unsigned VALUE_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  action,
	input  wire logic [31:0] value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      popped_value,
	output logic             found,
	output logic [3:0]       match_position,
	output logic [4:0]       entry_count,
	output logic             is_empty,
	output logic [1:0]       error_code
);

	localparam int unsigned IDX_W = $clog2(CAPACITY);
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	state_t                  state_q, state_d;
	logic [CNT_W-1:0]        count_q, count_d;
	logic [IDX_W-1:0]        scan_q;
	logic                    out_valid_q;
	action_t                 act_q;
	logic [VALUE_BITS-1:0]   val_q;
	logic [VALUE_BITS-1:0]   popped_q;
	logic                    found_q;
	logic [IDX_W-1:0]        pos_q;
	err_t                    err_q;

	action_t                 act;
	logic                    in_fire;
	logic                    full;
	logic                    empty;
	logic                    scan_last;
	logic                    scan_hit;
	logic                    scan_back;
	logic                    start_scan;
	logic                    res_load;
	err_t                    res_err;
	logic [VALUE_BITS-1:0]   res_popped;
	logic                    push_back_en;
	shift_ctrl_t             shift_ctrl;

	logic [VALUE_BITS+31:0]  vin_ext;
	logic [VALUE_BITS-1:0]   val_in;
	logic [VALUE_BITS+31:0]  pop_ext;
	logic [IDX_W+3:0]        pos_ext;
	logic [CNT_W+4:0]        cnt_ext;

	logic [VALUE_BITS-1:0]   cell_data [CAPACITY];

	assign act       = action_t'(action);
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_fire   = in_valid && in_ready;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign scan_last = (scan_q == IDX_W'(CAPACITY - 1));
	assign scan_hit  = (act_q == ACT_FIND) && !found_q && (CNT_W'(scan_q) < count_q)
		&& (cell_data[0] == val_q);
	assign scan_back = (act_q == ACT_POP_BACK) && (CNT_W'(scan_q) == count_q - CNT_W'(1));

	assign vin_ext = {{VALUE_BITS{1'b0}}, value};
	assign val_in  = vin_ext[VALUE_BITS-1:0];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		bdq_cell #(
			.WIDTH(VALUE_BITS)
		) u_cell (
			.clk       (clk),
			.ctrl      (shift_ctrl),
			.load      (push_back_en && (count_q == CNT_W'(i))),
			.load_data (val_in),
			.left_data ((i == 0) ? val_in : cell_data[(i + CAPACITY - 1) % CAPACITY]),
			.right_data(cell_data[(i + 1) % CAPACITY]),
			.data      (cell_data[i])
		);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && start_scan) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		shift_ctrl   = '0;
		push_back_en = 1'b0;
		start_scan   = 1'b0;
		res_load     = 1'b0;
		res_err      = ERR_OK;
		res_popped   = '0;
		count_d      = count_q;
		if (state_q == ST_IDLE && in_fire) begin
			unique case (act)
				ACT_PUSH_FRONT: begin
					res_load = 1'b1;
					if (full) begin
						res_err = ERR_PUSH_FULL;
					end else begin
						shift_ctrl.shift_r = 1'b1;
						count_d = count_q + CNT_W'(1);
					end
				end
				ACT_PUSH_BACK: begin
					res_load = 1'b1;
					if (full) begin
						res_err = ERR_PUSH_FULL;
					end else begin
						push_back_en = 1'b1;
						count_d = count_q + CNT_W'(1);
					end
				end
				ACT_POP_FRONT: begin
					res_load = 1'b1;
					if (empty) begin
						res_err = ERR_POP_EMPTY;
					end else begin
						res_popped = cell_data[0];
						shift_ctrl.shift_l = 1'b1;
						count_d = count_q - CNT_W'(1);
					end
				end
				ACT_POP_BACK: begin
					if (empty) begin
						res_load = 1'b1;
						res_err = ERR_POP_EMPTY;
					end else begin
						start_scan = 1'b1;
					end
				end
				ACT_FIND: begin
					if (empty) begin
						res_load = 1'b1;
					end else begin
						start_scan = 1'b1;
					end
				end
				ACT_CLEAR: begin
					res_load = 1'b1;
					count_d = '0;
				end
				default: begin
					res_load = 1'b1;
				end
			endcase
		end else if (state_q == ST_SCAN) begin
			shift_ctrl.shift_l = 1'b1;
			if (scan_last && act_q == ACT_POP_BACK) begin
				count_d = count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (state_q == ST_SCAN && !scan_last) begin
				scan_q <= scan_q + IDX_W'(1);
			end else begin
				scan_q <= '0;
			end
			if (res_load || (state_q == ST_SCAN && scan_last)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			act_q <= act;
			val_q <= val_in;
		end
		if (res_load) begin
			popped_q <= res_popped;
			found_q  <= 1'b0;
			pos_q    <= '0;
			err_q    <= res_err;
		end else if (in_fire) begin
			popped_q <= '0;
			found_q  <= 1'b0;
			pos_q    <= '0;
			err_q    <= ERR_OK;
		end else if (state_q == ST_SCAN) begin
			if (scan_hit) begin
				found_q <= 1'b1;
				pos_q   <= scan_q;
			end
			if (scan_back) begin
				popped_q <= cell_data[0];
			end
		end
	end

	assign pop_ext = {32'd0, popped_q};
	assign pos_ext = {4'd0, pos_q};
	assign cnt_ext = {5'd0, count_q};

	assign out_valid      = out_valid_q;
	assign popped_value   = pop_ext[31:0];
	assign found          = found_q;
	assign match_position = pos_ext[3:0];
	assign entry_count    = cnt_ext[4:0];
	assign is_empty       = empty;
	assign error_code     = err_q;

endmodule

`default_nettype wire

@@ hw/rtl/bdq_checker.sv @@
// Port-level checks for the bounded deque, bound to its top level.
`default_nettype none

module bdq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [2:0]  action,
	input wire logic [31:0] value,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] popped_value,
	input wire logic        found,
	input wire logic [3:0]  match_position,
	input wire logic [4:0]  entry_count,
	input wire logic        is_empty,
	input wire logic [1:0]  error_code
);

	logic unused_inputs;
	assign unused_inputs = in_valid ^ (^action) ^ (^value);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(popped_value)
			&& $stable(error_code) && $stable(entry_count))
		else $error("Result changed or dropped while stalled.");

	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("Item accepted while a result is stalled.");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> is_empty == (entry_count == 5'd0))
		else $error("Empty flag disagrees with entry count.");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != 2'd0 |-> popped_value == 32'd0 && !found)
		else $error("Failed action reported data.");

	a_no_match_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_position == 4'd0)
		else $error("Position reported without a match.");

endmodule

bind bounded_deque_with_search bdq_checker u_bdq_checker (.*);

`default_nettype wire

@@ tb/sv/bounded_deque_with_search_tb.sv @@
// Self-checking testbench for the bounded deque with linear search, with a transaction-level predictor.
`default_nettype none

module bounded_deque_with_search_tb;
	import bdq_pkg::*;

	localparam int DEPTH       = 16;
	localparam int DRAIN_WAIT  = 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_BLOCKS = 15;
	localparam int BLOCK_ITEMS = 30;

	typedef struct packed {
		logic [2:0]  act;
		logic [31:0] val;
		logic [7:0]  gap;
	} deque_op_t;

	typedef struct packed {
		logic [31:0] popped;
		logic        found;
		logic [3:0]  pos;
		logic [4:0]  count;
		logic        empty;
		logic [1:0]  err;
	} deque_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  action = '0;
	logic [31:0] value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] popped_value;
	logic        found;
	logic [3:0]  match_position;
	logic [4:0]  entry_count;
	logic        is_empty;
	logic [1:0]  error_code;

	deque_op_t     pending_ops[$];
	deque_result_t expected_results[$];

	logic [31:0] shadow_slots [DEPTH];
	logic [3:0]  shadow_head = '0;
	logic [4:0]  shadow_fill = '0;

	int  mismatches = 0;
	int  cycles = 0;
	int  send_gap = 0;
	int  stall_left = 0;
	int  calm_left = 0;
	bit  quiet = 1'b0;

	bounded_deque_with_search dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.popped_value(popped_value),
		.found(found),
		.match_position(match_position),
		.entry_count(entry_count),
		.is_empty(is_empty),
		.error_code(error_code)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int idle_len();
		if ($urandom_range(0, 99) < 80)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %0h, expected %0h", what, got, want);
		mismatches++;
	endtask

	task automatic deque_apply(input logic [2:0] act, input logic [31:0] val);
		deque_result_t r;
		logic [3:0] slot;
		int i;
		r = '0;
		r.err = ERR_OK;
		case (act)
		ACT_PUSH_FRONT: begin
			if (shadow_fill == DEPTH) begin
				r.err = ERR_PUSH_FULL;
			end else begin
				shadow_head = shadow_head - 4'd1;
				shadow_slots[shadow_head] = val;
				shadow_fill = shadow_fill + 5'd1;
			end
		end
		ACT_PUSH_BACK: begin
			if (shadow_fill == DEPTH) begin
				r.err = ERR_PUSH_FULL;
			end else begin
				slot = shadow_head + shadow_fill[3:0];
				shadow_slots[slot] = val;
				shadow_fill = shadow_fill + 5'd1;
			end
		end
		ACT_POP_FRONT: begin
			if (shadow_fill == 0) begin
				r.err = ERR_POP_EMPTY;
			end else begin
				r.popped = shadow_slots[shadow_head];
				shadow_head = shadow_head + 4'd1;
				shadow_fill = shadow_fill - 5'd1;
			end
		end
		ACT_POP_BACK: begin
			if (shadow_fill == 0) begin
				r.err = ERR_POP_EMPTY;
			end else begin
				slot = shadow_head + shadow_fill[3:0] - 4'd1;
				r.popped = shadow_slots[slot];
				shadow_fill = shadow_fill - 5'd1;
			end
		end
		ACT_FIND: begin
			for (i = 0; i < shadow_fill; i++) begin
				slot = shadow_head + i[3:0];
				if (!r.found && shadow_slots[slot] == val) begin
					r.found = 1'b1;
					r.pos = i[3:0];
				end
			end
		end
		ACT_CLEAR: begin
			shadow_fill = '0;
			shadow_head = '0;
		end
		default: begin
		end
		endcase
		r.count = shadow_fill;
		r.empty = (shadow_fill == 0);
		expected_results.push_back(r);
	endtask

	task automatic add_op(input logic [2:0] act, input logic [31:0] val);
		deque_op_t op;
		op.act = act;
		op.val = val;
		if (quiet || $urandom_range(0, 1) == 0)
			op.gap = '0;
		else
			op.gap = 8'(idle_len());
		pending_ops.push_back(op);
	endtask

	function automatic logic [31:0] pick_value();
		int r;
		int k;
		r = $urandom_range(0, 99);
		k = $urandom_range(0, 31);
		if (r < 70)
			return $urandom_range(0, 11);
		if (r < 85)
			return $urandom;
		if (r < 90)
			return 32'hFFFF_FFFF;
		if (r < 95)
			return 32'h1 << k;
		return ~(32'h1 << k);
	endfunction

	function automatic logic [2:0] pick_action(input int mode);
		int r;
		logic [2:0] push;
		logic [2:0] pop;
		r = $urandom_range(0, 99);
		push = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
		pop = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
		if (r < 2)
			return ACT_CLEAR;
		if (r < 4)
			return 3'($urandom_range(6, 7));
		case (mode)
		0: return (r < 64) ? push : (r < 80) ? pop : ACT_FIND;
		1: return (r < 30) ? push : (r < 70) ? pop : ACT_FIND;
		default: return (r < 45) ? push : (r < 70) ? pop : ACT_FIND;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin : driver
		deque_op_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= '0;
			value <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				deque_apply(action, value);
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					nxt = pending_ops.pop_front();
					in_valid <= 1'b1;
					action <= nxt.act;
					value <= nxt.val;
					send_gap <= int'(nxt.gap);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		deque_result_t want;
		int r;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
			calm_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result, popped_value", popped_value, '0);
				end else begin
					want = expected_results.pop_front();
					if (popped_value !== want.popped)
						report_mismatch("popped_value", popped_value, want.popped);
					if (found !== want.found)
						report_mismatch("found", found, want.found);
					if (match_position !== want.pos)
						report_mismatch("match_position", match_position, want.pos);
					if (entry_count !== want.count)
						report_mismatch("entry_count", entry_count, want.count);
					if (is_empty !== want.empty)
						report_mismatch("is_empty", is_empty, want.empty);
					if (error_code !== want.err)
						report_mismatch("error_code", error_code, want.err);
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (calm_left > 0) begin
					calm_left <= calm_left - 1;
				end else begin
					r = $urandom_range(0, 99);
					if (r < 15)
						stall_left <= idle_len();
					else if (r < 17)
						calm_left <= $urandom_range(40, 200);
				end
			end
		end
	end

	initial begin : stimulus
		int b;
		int n;
		int mode;
		add_op(ACT_POP_FRONT, 32'h0);
		add_op(ACT_POP_BACK, 32'hFFFF_FFFF);
		add_op(ACT_FIND, 32'h0);
		add_op(3'd6, 32'hFFFF_FFFF);
		add_op(3'd7, 32'h0);
		for (n = 0; n < DEPTH; n++) begin
			if (n == 0)
				add_op(ACT_PUSH_FRONT, 32'h0);
			else if (n == 1)
				add_op(ACT_PUSH_BACK, 32'hFFFF_FFFF);
			else if (n == DEPTH - 1)
				add_op(ACT_PUSH_BACK, 32'h8000_0001);
			else
				add_op((n % 2) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, n % 5);
		end
		add_op(ACT_PUSH_FRONT, 32'h5A5A_5A5A);
		add_op(ACT_PUSH_BACK, 32'hA5A5_A5A5);
		add_op(ACT_FIND, 32'h8000_0001);
		add_op(ACT_FIND, 32'h0);
		add_op(ACT_FIND, 32'h1234_5678);
		add_op(ACT_POP_FRONT, 32'h0);
		add_op(ACT_POP_BACK, 32'h0);
		add_op(ACT_CLEAR, 32'hFFFF_FFFF);
		add_op(ACT_FIND, 32'h0);

		for (b = 0; b < RAND_BLOCKS; b++) begin
			mode = $urandom_range(0, 2);
			quiet = ($urandom_range(0, 3) == 0);
			for (n = 0; n < BLOCK_ITEMS; n++)
				add_op(pick_action(mode), pick_value());
		end
		quiet = 1'b0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		while (expected_results.size() != 0) begin
			void'(expected_results.pop_front());
			report_mismatch("missing result, count left", expected_results.size(), 0);
		end

		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
